@@ src/msp_pkg.sv @@
// Shared types, constants and a helper function of the matrix saddle point finder.
package msp_pkg;

    localparam int DATA_W       = 32;
    localparam int SIZE_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;
    localparam int OUT_TDATA_W  = 40;
    localparam int DEF_MAX_ROWS = 8;
    localparam int DEF_MAX_COLS = 8;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    typedef struct packed {
        logic [SIZE_W-1:0] rows;
        logic [SIZE_W-1:0] cols;
    } job_t;

    typedef struct packed {
        logic              active;
        logic [SIZE_W-1:0] row;
        logic [SIZE_W-1:0] col;
    } scan_req_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_FLUSH
    } back_state_t;

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] max_v);
        logic [SIZE_W-1:0] res;
        priority if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > max_v) begin
            res = max_v;
        end else begin
            res = v;
        end
        return res;
    endfunction

endpackage

@@ src/matrix_saddle_point_finder.sv @@
// Top level of the matrix saddle point finder: front end, job queue, matrix RAM and scan.
//
// Channel   Direction  Word contents
// s_        in         tdata[31:0] element value, row-major order
// m_        out        tdata row, column, value; tuser found; tlast end of run
// cfg_      in         index 0 row count, index 1 column count
//
// Elements are taken one per cycle while the matrix loads.
// After the final element the scan reads each element in turn through the single read port of the
// matrix RAM and can be held by an output stall; no elements are taken during the scan.
// Reset is synchronous and clears control state only; the matrix RAM needs no clearing.
// A stalled result register holds the scan, which in turn holds the input side.
module matrix_saddle_point_finder #(
    parameter int MAX_ROWS = msp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = msp_pkg::DEF_MAX_COLS
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [msp_pkg::DATA_W-1:0]      s_tdata,   // [31:0] element_value
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [msp_pkg::OUT_TDATA_W-1:0] m_tdata,   // [3:0] row, [7:4] column, [39:8] value
    output logic                            m_tuser,   // [0] found
    output logic                            m_tlast
);
    import msp_pkg::*;

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                     ram_wr_en;
    logic [ADDR_W-1:0]        ram_wr_addr;
    logic [DATA_W-1:0]        ram_wr_data;
    logic [ADDR_W-1:0]        ram_rd_addr;
    logic [DATA_W-1:0]        ram_rd_data;
    logic                     job_push;
    job_t                     push_job;
    job_t                     head_job;
    logic                     job_pop;
    logic                     fifo_empty;
    scan_req_t                scan_req;
    logic signed [DATA_W-1:0] row_min;
    logic signed [DATA_W-1:0] col_max;

    msp_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .ram_wr_en   (ram_wr_en),
        .ram_wr_addr (ram_wr_addr),
        .ram_wr_data (ram_wr_data),
        .job_push    (job_push),
        .job         (push_job),
        .fifo_empty  (fifo_empty),
        .scan_req    (scan_req),
        .row_min     (row_min),
        .col_max     (col_max)
    );

    msp_job_fifo u_job_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .pop      (job_pop),
        .head_job (head_job),
        .empty    (fifo_empty)
    );

    msp_ram #(
        .WIDTH  (DATA_W),
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_matrix_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    msp_back #(
        .MAX_COLS (MAX_COLS),
        .ADDR_W   (ADDR_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (!fifo_empty),
        .job         (head_job),
        .job_pop     (job_pop),
        .ram_rd_addr (ram_rd_addr),
        .ram_rd_data (ram_rd_data),
        .scan_req    (scan_req),
        .row_min     (row_min),
        .col_max     (col_max),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

`ifndef NO_ASSERTIONS
    a_no_intake_during_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        scan_req.active |-> !s_tready)
        else $error("element taken while a scan is running");

    a_push_into_empty_queue: assert property (@(posedge aclk) disable iff (!aresetn)
        job_push |-> fifo_empty)
        else $error("scan job queued behind another");

    a_none_result_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tlast && (m_tdata == '0)))
        else $error("empty result is not a lone zero word");

    a_found_indices_set: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata[3:0] != 4'd0) && (m_tdata[7:4] != 4'd0)))
        else $error("saddle point result with a zero index");
`endif

endmodule

@@ src/msp_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
module msp_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/msp_job_fifo.sv @@
// Two-entry queue of scan jobs between the load front end and the scan back end.
module msp_job_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  msp_pkg::job_t push_job,
    input  logic          pop,
    output msp_pkg::job_t head_job,
    output logic          empty
);
    import msp_pkg::*;

    job_t        mem_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        do_push;
    logic        do_pop;

    assign do_push = push && (count_reg != 2'd2);
    assign do_pop  = pop && (count_reg != 2'd0);

    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign head_job = mem_reg[rd_ptr_reg];
    assign empty    = (count_reg == 2'd0);

endmodule

@@ src/msp_front.sv @@
// Load front end: size registers, element intake, row minima and column maxima.
module msp_front #(
    parameter int MAX_ROWS = msp_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLS = msp_pkg::DEF_MAX_COLS,
    parameter int ADDR_W   = 6
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [msp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [msp_pkg::DATA_W-1:0]      s_tdata,
    output logic                            ram_wr_en,
    output logic [ADDR_W-1:0]               ram_wr_addr,
    output logic [msp_pkg::DATA_W-1:0]      ram_wr_data,
    output logic                            job_push,
    output msp_pkg::job_t                   job,
    input  logic                            fifo_empty,
    input  msp_pkg::scan_req_t              scan_req,
    output logic signed [msp_pkg::DATA_W-1:0] row_min,
    output logic signed [msp_pkg::DATA_W-1:0] col_max
);
    import msp_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int COL_W = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam logic [SIZE_W-1:0] ROWS_MAX = SIZE_W'(MAX_ROWS);
    localparam logic [SIZE_W-1:0] COLS_MAX = SIZE_W'(MAX_COLS);
    localparam logic [ADDR_W-1:0] COLS_STRIDE = ADDR_W'(MAX_COLS);

    logic [SIZE_W-1:0]        num_rows_reg, num_rows_next;
    logic [SIZE_W-1:0]        num_cols_reg, num_cols_next;
    logic [ROW_W-1:0]         load_row_reg, load_row_next;
    logic [COL_W-1:0]         load_col_reg, load_col_next;
    logic signed [DATA_W-1:0] row_min_reg [MAX_ROWS];
    logic signed [DATA_W-1:0] col_max_reg [MAX_COLS];

    logic [SIZE_W-1:0]        rows_c;
    logic [SIZE_W-1:0]        cols_c;
    logic                     accept;
    logic signed [DATA_W-1:0] value;
    logic                     col_last;
    logic                     row_last;
    logic [ROW_W-1:0]         rd_row;
    logic [COL_W-1:0]         rd_col;
    logic                     row_min_wr;
    logic                     col_max_wr;

    assign rows_c   = clamp_size(num_rows_reg, ROWS_MAX);
    assign cols_c   = clamp_size(num_cols_reg, COLS_MAX);
    assign s_tready = fifo_empty && !scan_req.active;
    assign accept   = s_tvalid && s_tready;
    assign value    = s_tdata;

    assign col_last = (SIZE_W'(load_col_reg) + SIZE_W'(1)) == cols_c;
    assign row_last = (SIZE_W'(load_row_reg) + SIZE_W'(1)) == rows_c;

    // The scan owns the read index while it runs; intake is held off then.
    assign rd_row  = scan_req.active ? scan_req.row[ROW_W-1:0] : load_row_reg;
    assign rd_col  = scan_req.active ? scan_req.col[COL_W-1:0] : load_col_reg;
    assign row_min = row_min_reg[rd_row];
    assign col_max = col_max_reg[rd_col];

    assign row_min_wr = accept && ((load_col_reg == '0) || (value < row_min));
    assign col_max_wr = accept && ((load_row_reg == '0) || (value > col_max));

    assign ram_wr_en   = accept;
    assign ram_wr_addr = ADDR_W'(load_row_reg) * COLS_STRIDE + ADDR_W'(load_col_reg);
    assign ram_wr_data = s_tdata;

    assign job_push = accept && col_last && row_last;
    assign job.rows = rows_c;
    assign job.cols = cols_c;

    always_comb begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        if (accept) begin
            if (col_last) begin
                load_col_next = '0;
                load_row_next = row_last ? '0 : load_row_reg + ROW_W'(1);
            end else begin
                load_col_next = load_col_reg + COL_W'(1);
            end
        end
        if (cfg_wr_en && (cfg_index == REG_NUM_ROWS)) begin
            num_rows_next = cfg_wdata;
            load_row_next = '0;
            load_col_next = '0;
        end else if (cfg_wr_en && (cfg_index == REG_NUM_COLS)) begin
            num_cols_next = cfg_wdata;
            load_row_next = '0;
            load_col_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_rows_reg <= SIZE_W'(1);
            num_cols_reg <= SIZE_W'(1);
            load_row_reg <= '0;
            load_col_reg <= '0;
        end else begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (row_min_wr) begin
            row_min_reg[load_row_reg] <= value;
        end
        if (col_max_wr) begin
            col_max_reg[load_col_reg] <= value;
        end
    end

endmodule

@@ src/msp_back.sv @@
// Scan back end: walks the stored matrix, tests each element and drives the result stream.
module msp_back #(
    parameter int MAX_COLS = msp_pkg::DEF_MAX_COLS,
    parameter int ADDR_W   = 6
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              job_valid,
    input  msp_pkg::job_t                     job,
    output logic                              job_pop,
    output logic [ADDR_W-1:0]                 ram_rd_addr,
    input  logic signed [msp_pkg::DATA_W-1:0] ram_rd_data,
    output msp_pkg::scan_req_t                scan_req,
    input  logic signed [msp_pkg::DATA_W-1:0] row_min,
    input  logic signed [msp_pkg::DATA_W-1:0] col_max,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [msp_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                              m_tuser,
    output logic                              m_tlast
);
    import msp_pkg::*;

    localparam logic [ADDR_W-1:0] COLS_STRIDE = ADDR_W'(MAX_COLS);

    back_state_t              state_reg, state_next;
    logic [SIZE_W-1:0]        i_reg, i_next;
    logic [SIZE_W-1:0]        j_reg, j_next;
    logic [SIZE_W-1:0]        rows_reg, rows_next;
    logic [SIZE_W-1:0]        cols_reg, cols_next;
    logic                     pend_valid_reg, pend_valid_next;
    logic [SIZE_W-1:0]        pend_row_reg, pend_row_next;
    logic [SIZE_W-1:0]        pend_col_reg, pend_col_next;
    logic [DATA_W-1:0]        pend_value_reg, pend_value_next;
    logic                     out_valid_reg, out_valid_next;
    logic                     out_found_reg, out_found_next;
    logic [SIZE_W-1:0]        out_row_reg, out_row_next;
    logic [SIZE_W-1:0]        out_col_reg, out_col_next;
    logic [DATA_W-1:0]        out_value_reg, out_value_next;
    logic                     out_last_reg, out_last_next;

    logic                     out_free;
    logic                     match;
    logic                     need_out;
    logic                     proceed;
    logic                     scan_end;
    logic                     col_end;

    assign out_free = !out_valid_reg || m_tready;
    assign match    = (ram_rd_data == row_min) && (ram_rd_data == col_max);
    assign need_out = match && pend_valid_reg;
    assign proceed  = !need_out || out_free;
    assign col_end  = (j_reg + SIZE_W'(1)) == cols_reg;
    assign scan_end = col_end && ((i_reg + SIZE_W'(1)) == rows_reg);

    assign ram_rd_addr     = ADDR_W'(i_reg) * COLS_STRIDE + ADDR_W'(j_reg);
    assign scan_req.active = (state_reg != BK_IDLE);
    assign scan_req.row    = i_reg;
    assign scan_req.col    = j_reg;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    state_next = BK_READ;
                end
            end
            BK_READ: begin
                state_next = BK_CHECK;
            end
            BK_CHECK: begin
                if (proceed) begin
                    state_next = scan_end ? BK_FLUSH : BK_READ;
                end
            end
            BK_FLUSH: begin
                if (out_free) begin
                    state_next = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_comb begin
        job_pop         = 1'b0;
        i_next          = i_reg;
        j_next          = j_reg;
        rows_next       = rows_reg;
        cols_next       = cols_reg;
        pend_valid_next = pend_valid_reg;
        pend_row_next   = pend_row_reg;
        pend_col_next   = pend_col_reg;
        pend_value_next = pend_value_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_found_next  = out_found_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            BK_IDLE: begin
                if (job_valid) begin
                    job_pop         = 1'b1;
                    rows_next       = job.rows;
                    cols_next       = job.cols;
                    i_next          = '0;
                    j_next          = '0;
                    pend_valid_next = 1'b0;
                end
            end
            BK_READ: begin
            end
            BK_CHECK: begin
                if (proceed) begin
                    // A new match releases the one held before it, which is then not the last.
                    if (need_out) begin
                        out_valid_next = 1'b1;
                        out_found_next = 1'b1;
                        out_row_next   = pend_row_reg;
                        out_col_next   = pend_col_reg;
                        out_value_next = pend_value_reg;
                        out_last_next  = 1'b0;
                    end
                    if (match) begin
                        pend_valid_next = 1'b1;
                        pend_row_next   = i_reg + SIZE_W'(1);
                        pend_col_next   = j_reg + SIZE_W'(1);
                        pend_value_next = ram_rd_data;
                    end
                    if (!scan_end) begin
                        if (col_end) begin
                            j_next = '0;
                            i_next = i_reg + SIZE_W'(1);
                        end else begin
                            j_next = j_reg + SIZE_W'(1);
                        end
                    end
                end
            end
            BK_FLUSH: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_found_next  = pend_valid_reg;
                    out_row_next    = pend_valid_reg ? pend_row_reg : '0;
                    out_col_next    = pend_valid_reg ? pend_col_reg : '0;
                    out_value_next  = pend_valid_reg ? pend_value_reg : '0;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BK_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        i_reg          <= i_next;
        j_reg          <= j_next;
        rows_reg       <= rows_next;
        cols_reg       <= cols_next;
        pend_row_reg   <= pend_row_next;
        pend_col_reg   <= pend_col_next;
        pend_value_reg <= pend_value_next;
        out_found_reg  <= out_found_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_found_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {out_value_reg, out_col_reg, out_row_reg};

endmodule

@@ dv/tb.sv @@
// Self-checking testbench of the matrix saddle point finder: directed table, then random matrices.
`timescale 1ns / 100ps

module tb;

    localparam int MAX_DIM       = 8;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 245;
    localparam int CALM_ITEMS    = 40;
    localparam int SCAN_TAIL     = 2 * MAX_DIM * MAX_DIM + 18;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 1000000;

    localparam logic [msp_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd2;

    typedef enum int {
        FILL_RANDOM,
        FILL_NARROW,
        FILL_FLAT,
        FILL_EXTREME,
        FILL_RAMP
    } fill_mode_t;

    typedef struct packed {
        logic        found;
        logic [3:0]  row;
        logic [3:0]  col;
        logic [31:0] value;
        logic        end_of_run;
    } saddle_t;

    typedef struct packed {
        logic        set_size;
        logic [3:0]  rows_w;
        logic [3:0]  cols_w;
        logic [31:0] value;
        logic        typed;
        saddle_t     result;
    } directed_row_t;

    localparam saddle_t NO_POINT = '{1'b0, 4'd0, 4'd0, 32'd0, 1'b1};

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [msp_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [msp_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [msp_pkg::DATA_W-1:0]      s_tdata   = '0;
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    logic [msp_pkg::OUT_TDATA_W-1:0] m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    matrix_saddle_point_finder u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic signed [31:0] cell_store [MAX_DIM*MAX_DIM];
    logic signed [31:0] row_min    [MAX_DIM];
    logic signed [31:0] col_max    [MAX_DIM];
    int                 ld_row     = 0;
    int                 ld_col     = 0;
    logic [3:0]         size_rows  = 4'd1;
    logic [3:0]         size_cols  = 4'd1;
    saddle_t            scan_out   [MAX_DIM*MAX_DIM];

    saddle_t point_queue [$];
    int      mismatches   = 0;
    int      results_seen = 0;
    int      sent_words   = 0;
    int      cycles       = 0;
    bit      calm         = 1'b0;

    directed_row_t plan [DIRECTED_ROWS] = '{
        '{1'b0, 4'd0, 4'd0, 32'h8000_0000, 1'b1, '{1'b1, 4'd1, 4'd1, 32'h8000_0000, 1'b1}},
        '{1'b0, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b1, '{1'b1, 4'd1, 4'd1, 32'h7FFF_FFFF, 1'b1}},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0000, 1'b1, '{1'b1, 4'd1, 4'd1, 32'h0000_0000, 1'b1}},
        '{1'b0, 4'd0, 4'd0, 32'hFFFF_FFFF, 1'b1, '{1'b1, 4'd1, 4'd1, 32'hFFFF_FFFF, 1'b1}},
        '{1'b1, 4'd0, 4'd0, 32'h0000_0005, 1'b1, '{1'b1, 4'd1, 4'd1, 32'h0000_0005, 1'b1}},
        '{1'b1, 4'd2, 4'd2, 32'h0000_0001, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0002, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0002, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0001, 1'b1, NO_POINT},
        '{1'b1, 4'd2, 4'd3, 32'h0000_0007, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0007, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0007, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0007, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0007, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0007, 1'b0, '0},
        '{1'b1, 4'd2, 4'd1, 32'hFFFF_FFFB, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'hFFFF_FFFD, 1'b1, '{1'b1, 4'd2, 4'd1, 32'hFFFF_FFFD, 1'b1}},
        '{1'b1, 4'd1, 4'd9, 32'h0000_0028, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'hFFFF_FFFE, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0011, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h7FFF_FFFF, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'hFFFF_FFFE, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0003, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h8000_0001, 1'b0, '0},
        '{1'b0, 4'd0, 4'd0, 32'h0000_0009, 1'b0, '0}
    };

    function automatic int fit_size(logic [3:0] raw);
        if (raw == 4'd0) return 1;
        if (raw > 4'(MAX_DIM)) return MAX_DIM;
        return int'(raw);
    endfunction

    // Loads one element and, when it completes the matrix, fills scan_out with the run.
    function automatic int absorb_element(logic signed [31:0] v);
        int r;
        int c;
        int n;
        r = ld_row;
        c = ld_col;
        n = 0;
        cell_store[r*MAX_DIM+c] = v;
        if (c == 0 || v < row_min[r]) row_min[r] = v;
        if (r == 0 || v > col_max[c]) col_max[c] = v;
        if (c + 1 < fit_size(size_cols)) begin
            ld_col = c + 1;
            return 0;
        end
        ld_col = 0;
        if (r + 1 < fit_size(size_rows)) begin
            ld_row = r + 1;
            return 0;
        end
        ld_row = 0;
        for (int i = 0; i < fit_size(size_rows); i++) begin
            for (int j = 0; j < fit_size(size_cols); j++) begin
                if (cell_store[i*MAX_DIM+j] == row_min[i] &&
                    cell_store[i*MAX_DIM+j] == col_max[j]) begin
                    scan_out[n] = '{1'b1, 4'(i + 1), 4'(j + 1), cell_store[i*MAX_DIM+j], 1'b0};
                    n++;
                end
            end
        end
        if (n == 0) begin
            scan_out[0] = NO_POINT;
            return 1;
        end
        scan_out[n-1].end_of_run = 1'b1;
        return n;
    endfunction

    task automatic write_reg(logic [msp_pkg::CFG_IDX_W-1:0] idx,
                             logic [msp_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == msp_pkg::REG_NUM_ROWS || idx == msp_pkg::REG_NUM_COLS) begin
            if (idx == msp_pkg::REG_NUM_ROWS) size_rows = val;
            else size_cols = val;
            ld_row = 0;
            ld_col = 0;
        end
        @(posedge aclk);
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (point_queue.size() != 0) @(posedge aclk);
        repeat (SCAN_TAIL) @(posedge aclk);
    endtask

    task automatic resize(logic [3:0] rows_w, logic [3:0] cols_w);
        settle();
        write_reg(msp_pkg::REG_NUM_ROWS, rows_w);
        write_reg(msp_pkg::REG_NUM_COLS, cols_w);
    endtask

    task automatic send_element(logic [31:0] v, bit typed, saddle_t typed_result);
        int n;
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_tdata  <= v;
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        sent_words++;
        n = absorb_element(v);
        if (typed) begin
            point_queue.push_back(typed_result);
        end else begin
            for (int k = 0; k < n; k++) point_queue.push_back(scan_out[k]);
        end
    endtask

    task automatic send_matrix(fill_mode_t mode);
        int          rows_n;
        int          cols_n;
        logic [31:0] base;
        logic [31:0] v;
        rows_n = fit_size(size_rows);
        cols_n = fit_size(size_cols);
        base   = (mode == FILL_RAMP) ? 32'($urandom_range(0, 2000)) - 32'd1000 : $urandom;
        for (int i = 0; i < rows_n; i++) begin
            for (int j = 0; j < cols_n; j++) begin
                case (mode)
                    FILL_NARROW: v = 32'($urandom_range(0, 6)) - 32'd3;
                    FILL_FLAT: v = base;
                    FILL_EXTREME: begin
                        case ($urandom_range(0, 3))
                            0: v = 32'h8000_0000;
                            1: v = 32'h7FFF_FFFF;
                            2: v = 32'h0000_0000;
                            default: v = 32'hFFFF_FFFF;
                        endcase
                    end
                    FILL_RAMP: v = base + 32'(i) - 32'(j);
                    default: v = $urandom;
                endcase
                send_element(v, 1'b0, '0);
            end
        end
    endtask

    always @(posedge aclk) begin : result_check
        saddle_t got;
        saddle_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = '{m_tuser, m_tdata[3:0], m_tdata[7:4], m_tdata[39:8], m_tlast};
            results_seen++;
            if (point_queue.size() == 0) begin
                want = '0;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: found=%0b row=%0d col=%0d value=%0d last=%0b",
                             got.found, got.row, got.col, $signed(got.value), got.end_of_run);
            end else begin
                want = point_queue.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected found=%0b row=%0d col=%0d value=%0d last=%0b",
                                 want.found, want.row, want.col, $signed(want.value),
                                 want.end_of_run,
                                 ", got found=%0b row=%0d col=%0d value=%0d last=%0b",
                                 got.found, got.row, got.col,
                                 $signed(got.value), got.end_of_run);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin : result_sink
        int hold;
        bit held_long;
        held_long = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!held_long && !calm && results_seen > 0 && s_tvalid && !s_tready) begin
                m_tready <= 1'b0;
                for (hold = 0; hold < LONG_HOLD; hold++) @(posedge aclk);
                held_long = 1'b1;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    initial begin : stimulus
        int         phase;
        int         mats;
        logic [3:0] rows_w;
        logic [3:0] cols_w;
        fill_mode_t mode;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (plan[k]) begin
            if (plan[k].set_size) resize(plan[k].rows_w, plan[k].cols_w);
            send_element(plan[k].value, plan[k].typed, plan[k].result);
        end
        settle();
        write_reg(REG_SPARE, 4'hF);

        phase = 0;
        while (sent_words < DIRECTED_ROWS + RANDOM_ITEMS) begin
            mode = fill_mode_t'($urandom_range(0, 4));
            case (phase)
                0: begin
                    rows_w = 4'd15;
                    cols_w = 4'd15;
                end
                1: begin
                    rows_w = 4'd8;
                    cols_w = 4'd8;
                    mode   = FILL_FLAT;
                end
                2: begin
                    rows_w = 4'd0;
                    cols_w = 4'd8;
                end
                default: begin
                    rows_w = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(1, 4));
                    cols_w = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                                         : 4'($urandom_range(1, 4));
                end
            endcase
            resize(rows_w, cols_w);
            mats = (fit_size(rows_w) * fit_size(cols_w) > 16) ? 1 : $urandom_range(1, 4);
            repeat (mats) begin
                if (sent_words >= DIRECTED_ROWS + RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
                send_matrix(mode);
                mode = fill_mode_t'($urandom_range(0, 4));
            end
            phase++;
        end
        settle();

        if (mismatches == 0 && point_queue.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/msp_pkg.sv
src/msp_ram.sv
src/msp_job_fifo.sv
src/msp_front.sv
src/msp_back.sv
src/matrix_saddle_point_finder.sv
dv/tb.sv
